// ===== design/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// lir_pkg: shared constants for the linear interpolation resampler
// register map, step width and result cap per input item
// ----------------------------------------------------------------------------
package lir_pkg;

  // width of the rate_step register (unsigned fixed point)
  localparam int STEP_W = 21;

  // reset value of rate_step
  localparam logic [STEP_W-1:0] RATE_STEP_RESET = 21'd65536;

  // most results one input item may cause, and a counter that holds it
  localparam int RESULT_CAP = 32;
  localparam int CNT_W      = 6;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_RATE_STEP = 1'b0;

endpackage

// ===== design/linear_interp_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler: streaming linear interpolation rate converter
// one mono source sample per item in, zero or more interpolated samples out
// ----------------------------------------------------------------------------
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  -----------------------------------
// in       input      in_valid / in_stall   sample_in, final_in
// out      output     out_valid / out_stall sample_out, run_last, clip_end
// cfg      input      apb psel/penable      rate_step at byte address 0
//
// an item is taken while idle, then the sequencer runs while in_stall is
// high: each interpolated result takes a check, a multiply and an add step
// through the one shared multiplier; a repeated tail result, an interval
// exit and leaving the tail of a final item each take a check step, and
// the run of an item ends with a done step.
// a first non-final sample is only stored.
// rst is synchronous and clears state, position and the output valid flag.
// a stalled output holds; the sequencer waits while a queued result cannot move out.
// the last result may still sit in the output register when the next item
// is taken.
//
module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // source samples
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          final_in,
  // output samples
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          run_last,
  output logic                          clip_end,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready
);

  // position holds below one plus a full step
  localparam int POS_W = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 1;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << PHASE_FRAC_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                    state;
  logic [STEP_W-1:0]             rate_step;
  logic                          have_prev;
  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [SAMPLE_BITS:0]   diff;
  logic                          fin;
  logic                          tail;      // repeating cur past the last sample
  logic [POS_W-1:0]              pos;       // next output position from prev
  logic [CNT_W-1:0]              cnt;       // results made for this item

  // one result waits here until we know whether another follows
  logic                          pend_valid;
  logic signed [SAMPLE_BITS-1:0] pend_val;

  logic                          cfg_wr;
  logic                          out_free;
  logic                          pos_lt_one;
  logic                          cnt_lt_cap;
  logic                          more;
  logic                          push;      // queued result moves to the output
  logic [POS_W-1:0]              pos_step;
  logic signed [SAMPLE_BITS-1:0] lerp_value;

  // ---------------------------------------------------------------------------
  // configuration port: no wait states
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RATE_STEP) begin
      prdata = APB_DATA_W'(rate_step);
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer conditions
  // ---------------------------------------------------------------------------
  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign pos_lt_one = (pos < POS_ONE);
  assign cnt_lt_cap = (cnt < CNT_W'(RESULT_CAP));
  assign more       = pos_lt_one && cnt_lt_cap;
  assign pos_step   = pos + POS_W'(rate_step);
  assign push       = pend_valid && out_free &&
                      (((state == S_CHECK) && more) || (state == S_DONE));

  // shared multiplier: fraction of the position times (cur - prev)
  lir_lerp_unit #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_lerp (
    .clk    (clk),
    .mul_en (state == S_MUL),
    .frac   (pos[PHASE_FRAC_BITS-1:0]),
    .diff   (diff),
    .prev   (prev),
    .value  (lerp_value)
  );

  // ---------------------------------------------------------------------------
  // sequencer, state and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rate_step  <= RATE_STEP_RESET;
      have_prev  <= 1'b0;
      prev       <= '0;
      pos        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_RATE_STEP) begin
        rate_step <= pwdata[STEP_W-1:0];
      end

      // output loaded or taken
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur  <= sample_in;
            fin  <= final_in;
            diff <= (SAMPLE_BITS+1)'(sample_in) - (SAMPLE_BITS+1)'(prev);
            cnt  <= '0;
            // with no previous sample only the tail can produce results
            tail <= !have_prev;
            if (have_prev || final_in) begin
              state <= S_CHECK;
            end else begin
              prev      <= sample_in;
              have_prev <= 1'b1;
            end
          end
        end

        S_CHECK: begin
          // hold off while a queued result cannot move out
          if (!pend_valid || out_free) begin
            if (more) begin
              // another result follows, so the queued one is not the last
              if (pend_valid) begin
                sample_out <= pend_val;
                run_last   <= 1'b0;
                clip_end   <= 1'b0;
              end
              if (tail) begin
                pend_val   <= cur;
                pend_valid <= 1'b1;
                pos        <= pos_step;
                cnt        <= cnt + 1'b1;
              end else begin
                pend_valid <= 1'b0;
                state      <= S_MUL;
              end
            end else if (!tail) begin
              // leave the interval; a capped run restarts at the next sample
              pos <= pos_lt_one ? '0 : pos - POS_ONE;
              if (fin) begin
                tail <= 1'b1;
              end else begin
                state <= S_DONE;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end

        S_MUL: begin
          state <= S_ADD;
        end

        S_ADD: begin
          pend_val   <= lerp_value;
          pend_valid <= 1'b1;
          pos        <= pos_step;
          cnt        <= cnt + 1'b1;
          state      <= S_CHECK;
        end

        S_DONE: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              sample_out <= pend_val;
              run_last   <= 1'b1;
              clip_end   <= fin;
              pend_valid <= 1'b0;
            end
            if (fin) begin
              // clip over: back to the reset state
              prev      <= '0;
              pos       <= '0;
              have_prev <= 1'b0;
            end else begin
              prev      <= cur;
              have_prev <= 1'b1;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/lir_lerp_unit.sv =====
// ----------------------------------------------------------------------------
// lir_lerp_unit: shared multiply and add for one interpolated sample
// registered frac*diff product, then prev plus the floored product
// ----------------------------------------------------------------------------
module lir_lerp_unit #(
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          mul_en,
  input  logic [PHASE_FRAC_BITS-1:0]    frac,
  input  logic signed [SAMPLE_BITS:0]   diff,
  input  logic signed [SAMPLE_BITS-1:0] prev,
  output logic signed [SAMPLE_BITS-1:0] value
);

  localparam int PROD_W = SAMPLE_BITS + PHASE_FRAC_BITS + 2;

  logic signed [PROD_W-1:0] prod;

  // frac is unsigned, so it gets a zero sign bit
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= $signed({1'b0, frac}) * diff;
    end
  end

  // arithmetic shift floors; the sum always lies between prev and cur,
  // so only the low bits are needed
  assign value = prev + prod[PHASE_FRAC_BITS +: SAMPLE_BITS];

endmodule

// ===== design/lir_checker.sv =====
// ----------------------------------------------------------------------------
// lir_checker: port-level checks for the linear interpolation resampler
// bound to the top level
// ----------------------------------------------------------------------------
module lir_checker
  import lir_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_in,
  input logic                          final_in,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          run_last,
  input logic                          clip_end,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [APB_ADDR_W-1:0]         paddr,
  input logic [APB_DATA_W-1:0]         pwdata,
  input logic [APB_DATA_W-1:0]         prdata,
  input logic                          pready
);

  // taking a final item always makes the block busy in the next cycle
  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && final_in) |=> in_stall)
    else $error("final item did not start a run");

  // the end of a clip is always the end of a run
  a_clip_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clip_end) |-> run_last)
    else $error("clip_end without run_last");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled output holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(sample_out) && $stable(run_last) && $stable(clip_end)))
    else $error("stalled output item changed");

endmodule

bind linear_interp_resampler lir_checker #(
  .SAMPLE_BITS     (SAMPLE_BITS),
  .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
) u_lir_checker (.*);
